@@ src/srr_pkg.sv @@
// Shared constants, types and state codes for the selective-repeat receiver.
package srr_pkg;

  localparam int SEQ_W          = 16;   // sequence number width
  localparam int WIN_W          = 5;    // receive window register width
  localparam int WINDOW_MAX_DEF = 16;   // default ring depth
  localparam int PAYLOAD_BYTES  = 20;
  localparam int WORD_W         = 32;
  localparam int WORDS          = 5;
  localparam int PAY_W          = WORDS * WORD_W;       // 160
  localparam int CHK_W          = 32;                   // carried checksum
  localparam int ACK_CHK_W      = SEQ_W + 1;            // 2*seq
  localparam int SUM_W          = SEQ_W + 3;            // seq+ack+bytes, signed
  localparam int IN_TDATA_W     = 2 * SEQ_W + CHK_W + PAY_W;            // 224
  localparam int OUT_RAW_W      = SEQ_W + ACK_CHK_W + PAY_W;            // 193
  localparam int OUT_TDATA_W    = ((OUT_RAW_W + 7) / 8) * 8;            // 200

  localparam logic [WIN_W-1:0] WIN_RESET = 5'd8;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a packet
    S_CHECK,  // checksum compare, window test, ack and store
    S_RD,     // ring read of the expected slot in flight
    S_DLV     // deliver the expected slot
  } state_t;

endpackage

@@ src/selective_repeat_receiver.sv @@
// Selective-repeat ARQ receiver: checksum, receive window, payload ring, in-order delivery.
// Order: the ack is loaded into the output register from the check step; each
//   delivery follows via the registered ring read, then the output register.
// Flow: one packet at a time, with its deliveries; input is taken only
//   in idle, and a full output register stalls the check and delivery steps.
// Reset (rst_n low, synchronous): window 8, next expected 0, all slots empty;
//   no clearing pass, the ring payload is only read from filled slots.
module selective_repeat_receiver #(
  parameter int WINDOW_MAX = srr_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: receive window width
  input  logic                             cfg_wr_en,
  input  logic [srr_pkg::WIN_W-1:0]        cfg_wr_data,
  // packet input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seq_num[15:0], ack_num[31:16], check_value[63:32], payload_w0..payload_w4[223:64]
  input  logic [srr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result output
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_seq[15:0], ack_check[32:16], out_w0..out_w4[192:33], zero pad[199:193]
  output logic [srr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // kind[0]: 0 ack to sender, 1 payload delivered
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [srr_pkg::SEQ_W-1:0] IDX_MASK = srr_pkg::SEQ_W'(WINDOW_MAX - 1);
  localparam logic [srr_pkg::SEQ_W-1:0] WMAX     = srr_pkg::SEQ_W'(WINDOW_MAX);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  srr_pkg::state_t state_r, state_nxt;

  logic [srr_pkg::WIN_W-1:0]   window_r;
  logic [srr_pkg::SEQ_W-1:0]   nexp_r;          // next expected sequence number
  logic [WINDOW_MAX-1:0]       filled_r;        // one valid bit per ring slot

  // captured packet
  logic [srr_pkg::SEQ_W-1:0]   seq_r;
  logic [srr_pkg::CHK_W-1:0]   chk_r;
  logic [srr_pkg::PAY_W-1:0]   pay_r;
  logic [srr_pkg::SUM_W-1:0]   sum_r, sum_nxt;  // signed checksum computed at capture

  // payload ring, registered read
  logic [srr_pkg::PAY_W-1:0]   ring_mem [WINDOW_MAX];
  logic [srr_pkg::PAY_W-1:0]   rd_data_r;

  // output register
  logic                        out_valid_r;
  logic                        out_kind_r, out_kind_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [srr_pkg::SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic [srr_pkg::ACK_CHK_W-1:0] out_chk_r, out_chk_nxt;
  logic [srr_pkg::PAY_W-1:0]   out_pay_r, out_pay_nxt;

  // control
  logic cap_en, out_load, mem_we, fill_set, fill_clr, nexp_inc;
  logic out_free;

  // ---------------------------------------------------------------------------
  // Checksum at capture: seq + ack + signed payload bytes up to first zero byte
  // ---------------------------------------------------------------------------
  // bytes past the first zero are masked off, then summed as a balanced tree
  always_comb begin
    logic                      run;
    logic [7:0]                b;
    logic [srr_pkg::SUM_W-1:0] term [srr_pkg::PAYLOAD_BYTES];
    logic [srr_pkg::SUM_W-1:0] wsum [srr_pkg::WORDS];
    run = 1'b1;
    for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
      b       = in_tdata[64 + 8*i +: 8];
      run     = run & (b != 8'd0);
      term[i] = run ? {{(srr_pkg::SUM_W-8){b[7]}}, b} : '0;
    end
    for (int k = 0; k < srr_pkg::WORDS; k++) begin
      wsum[k] = (term[4*k] + term[4*k+1]) + (term[4*k+2] + term[4*k+3]);
    end
    sum_nxt = ((wsum[0] + wsum[1]) + (wsum[2] + wsum[3]))
            + (wsum[4] + (srr_pkg::SUM_W'(in_tdata[15:0])
                          + srr_pkg::SUM_W'(in_tdata[31:16])));
  end

  // ---------------------------------------------------------------------------
  // Window test on the captured packet
  // ---------------------------------------------------------------------------
  logic [srr_pkg::SEQ_W-1:0] win_ext, win_eff, fwd, back;
  logic [IDX_W-1:0]          sidx, cidx, nidx;
  logic                      pkt_ok, in_win, in_back;

  assign win_ext = srr_pkg::SEQ_W'(window_r);
  always_comb begin
    if (win_ext == '0)       win_eff = srr_pkg::SEQ_W'(1);
    else if (win_ext > WMAX) win_eff = WMAX;
    else                     win_eff = win_ext;
  end

  assign fwd     = seq_r - nexp_r;
  assign back    = nexp_r - seq_r;
  assign pkt_ok  = ({{(srr_pkg::CHK_W-srr_pkg::SUM_W){sum_r[srr_pkg::SUM_W-1]}}, sum_r}
                    == chk_r);
  assign in_win  = fwd < win_eff;
  assign in_back = (back != '0) && (back <= win_eff);

  assign sidx = IDX_W'(seq_r & IDX_MASK);                          // packet's slot
  assign cidx = IDX_W'(nexp_r & IDX_MASK);                         // expected slot
  assign nidx = IDX_W'((nexp_r + srr_pkg::SEQ_W'(1)) & IDX_MASK);  // slot after it

  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srr_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = srr_pkg::S_CHECK;
      end
      srr_pkg::S_CHECK: begin
        if (!pkt_ok || !(in_win || in_back)) begin
          state_nxt = srr_pkg::S_IDLE;   // corrupt or outside both windows: dropped
        end else if (out_free) begin
          state_nxt = (in_win && fwd == '0) ? srr_pkg::S_RD : srr_pkg::S_IDLE;
        end
      end
      srr_pkg::S_RD: state_nxt = srr_pkg::S_DLV;
      srr_pkg::S_DLV: begin
        if (out_free) state_nxt = out_last_nxt ? srr_pkg::S_IDLE : srr_pkg::S_RD;
      end
      default: state_nxt = srr_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM: outputs and datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready    = 1'b0;
    cap_en       = 1'b0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    fill_set     = 1'b0;
    fill_clr     = 1'b0;
    nexp_inc     = 1'b0;
    out_kind_nxt = srr_pkg::KIND_ACK;
    out_last_nxt = 1'b1;
    out_seq_nxt  = seq_r;
    out_chk_nxt  = {seq_r, 1'b0};
    out_pay_nxt  = '0;
    case (state_r)
      srr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cap_en    = in_tvalid;
      end
      srr_pkg::S_CHECK: begin
        // ack goes out first; a hit on the expected slot is followed by deliveries
        out_last_nxt = !(in_win && fwd == '0);
        if (pkt_ok && (in_win || in_back) && out_free) begin
          out_load = 1'b1;
          if (in_win && !filled_r[sidx]) begin
            mem_we   = 1'b1;
            fill_set = 1'b1;
          end
        end
      end
      srr_pkg::S_RD: begin
        // rd_data_r picks up the expected slot at this edge
      end
      srr_pkg::S_DLV: begin
        out_kind_nxt = srr_pkg::KIND_DLV;
        out_seq_nxt  = nexp_r;
        out_chk_nxt  = '0;
        out_pay_nxt  = rd_data_r;
        // run ends when the following slot is empty (or is this same slot)
        out_last_nxt = !(filled_r[nidx] && (nidx != cidx));
        if (out_free) begin
          out_load = 1'b1;
          fill_clr = 1'b1;
          nexp_inc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srr_pkg::S_IDLE;
      window_r    <= srr_pkg::WIN_RESET;
      nexp_r      <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) window_r <= cfg_wr_data;
      if (nexp_inc)  nexp_r   <= nexp_r + srr_pkg::SEQ_W'(1);
      if (fill_set)  filled_r[sidx] <= 1'b1;
      if (fill_clr)  filled_r[cidx] <= 1'b0;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cap_en) begin
      seq_r <= in_tdata[15:0];
      chk_r <= in_tdata[63:32];
      pay_r <= in_tdata[223:64];
      sum_r <= sum_nxt;
    end
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
      out_seq_r  <= out_seq_nxt;
      out_chk_r  <= out_chk_nxt;
      out_pay_r  <= out_pay_nxt;
    end
  end

  // payload ring: write from the check step, read always at the expected slot
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[sidx] <= pay_r;
    rd_data_r <= ring_mem[cidx];
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_kind_r;
  assign out_tlast    = out_last_r;
  assign out_tdata    = {{(srr_pkg::OUT_TDATA_W-srr_pkg::OUT_RAW_W){1'b0}},
                         out_pay_r, out_chk_r, out_seq_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a delivery only ever reads a filled slot
  a_dlv_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srr_pkg::S_DLV && out_free) |-> filled_r[cidx])
    else $error("delivery from an empty slot");

  // a corrupt packet leaves no result and returns to idle
  a_corrupt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srr_pkg::S_CHECK && !pkt_ok) |=> (state_r == srr_pkg::S_IDLE))
    else $error("corrupt packet not dropped");

  // next expected only moves on a delivery
  a_nexp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != srr_pkg::S_DLV) |=> (nexp_r == $past(nexp_r)))
    else $error("next expected moved outside delivery");

  // a delivery is always preceded by the ring read state
  a_rd_before_dlv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srr_pkg::S_DLV && $past(state_r) != srr_pkg::S_DLV)
      |-> ($past(state_r) == srr_pkg::S_RD))
    else $error("delivery without ring read");

  // a delivered item carries no ack checksum
  a_dlv_chk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == srr_pkg::KIND_DLV) |-> (out_chk_r == '0))
    else $error("delivery with nonzero ack checksum");

endmodule

@@ tb/srr_checker.sv @@
// Scoreboard for the selective-repeat receiver: predicts acks and deliveries, checks each result.
module srr_checker
  import srr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [WIN_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic                 kind;
    logic [SEQ_W-1:0]     seq;
    logic [ACK_CHK_W-1:0] ack_check;
    logic [PAY_W-1:0]     words;
    logic                 last;
  } rx_result_t;

  logic [WIN_W-1:0]          win_reg;
  logic [SEQ_W-1:0]          next_seq;
  logic [WINDOW_MAX_DEF-1:0] slot_full;
  logic [PAY_W-1:0]          slot_data [WINDOW_MAX_DEF];
  rx_result_t                ack_dlv_q [$];
  rx_result_t                held;
  bit                        held_ok;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // seq + ack + signed payload bytes up to the first zero byte
  function automatic int frame_sum(input logic [IN_TDATA_W-1:0] pkt);
    int         sum;
    logic [7:0] b;
    sum = int'(pkt[SEQ_W-1:0]) + int'(pkt[2*SEQ_W-1:SEQ_W]);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = pkt[2*SEQ_W + CHK_W + 8*i +: 8];
      if (b == 8'd0) break;
      sum += int'($signed(b));
    end
    return sum;
  endfunction

  // one result is held back so the final one of a packet can get its last flag
  task automatic push_result(input logic kind, input logic [SEQ_W-1:0] seq,
                             input logic [PAY_W-1:0] words);
    if (held_ok) ack_dlv_q.push_back(held);
    held.kind      = kind;
    held.seq       = seq;
    held.ack_check = (kind == KIND_ACK) ? {seq, 1'b0} : '0;
    held.words     = words;
    held.last      = 1'b0;
    held_ok        = 1'b1;
  endtask

  task automatic rx_window_step(input logic [IN_TDATA_W-1:0] pkt);
    logic [SEQ_W-1:0] seq, fwd, back;
    int unsigned      w;
    int               s;
    seq     = pkt[SEQ_W-1:0];
    w       = (win_reg == 0) ? 1 : (win_reg > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_reg;
    fwd     = seq - next_seq;
    back    = next_seq - seq;
    held_ok = 1'b0;
    if (frame_sum(pkt) != $signed(pkt[2*SEQ_W +: CHK_W])) return;
    if (fwd < w) begin
      push_result(KIND_ACK, seq, '0);
      s = int'(seq) % WINDOW_MAX_DEF;
      if (!slot_full[s]) begin
        slot_full[s] = 1'b1;
        slot_data[s] = pkt[IN_TDATA_W-1 -: PAY_W];
      end
      if (fwd == 0) begin
        for (int g = 0; g < WINDOW_MAX_DEF; g++) begin
          s = int'(next_seq) % WINDOW_MAX_DEF;
          if (!slot_full[s]) break;
          push_result(KIND_DLV, next_seq, slot_data[s]);
          slot_full[s] = 1'b0;
          next_seq++;
        end
      end
    end else if (back >= 1 && back <= w) begin
      push_result(KIND_ACK, seq, '0);
    end
    if (held_ok) begin
      held.last = 1'b1;
      ack_dlv_q.push_back(held);
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    rx_result_t got, want;
    if (!rst_n) begin
      win_reg   = WIN_RESET;
      next_seq  = '0;
      slot_full = '0;
      ack_dlv_q.delete();
    end else begin
      // results first: nothing accepted on this edge can be answered on it
      if (out_tvalid && out_tready) begin
        got.kind      = out_tuser[0];
        got.seq       = out_tdata[SEQ_W-1:0];
        got.ack_check = out_tdata[SEQ_W +: ACK_CHK_W];
        got.words     = out_tdata[SEQ_W + ACK_CHK_W +: PAY_W];
        got.last      = out_tlast;
        if (ack_dlv_q.size() == 0) begin
          note_failure($sformatf("unexpected result: kind %0d seq %0d last %0d",
                                 got.kind, got.seq, got.last));
        end else begin
          want = ack_dlv_q.pop_front();
          if (got.kind !== want.kind || got.seq !== want.seq ||
              got.ack_check !== want.ack_check || got.words !== want.words ||
              got.last !== want.last) begin
            note_failure($sformatf(
              "mismatch: exp kind %0d seq %0d chk %0d last %0d words %h",
              want.kind, want.seq, want.ack_check, want.last, want.words));
            if (fail_count <= 10)
              $display("          got kind %0d seq %0d chk %0d last %0d words %h",
                       got.kind, got.seq, got.ack_check, got.last, got.words);
          end
        end
      end
      if (cfg_wr_en) win_reg = cfg_wr_data;
      if (in_tvalid && in_tready) rx_window_step(in_tdata);
    end
    pending = ack_dlv_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the selective-repeat receiver: clock, reset, packet stimulus and verdict.
module tb_top;
  import srr_pkg::*;

  localparam int ITEM_TARGET  = 320;   // packets to send at least, directed part included
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;     // covers packets still in flight that give no result

  // payload byte fill before the terminating zero byte
  typedef enum int { FILL_RAND, FILL_MIN, FILL_MAX, FILL_NEG1 } fill_t;
  // how the carried checksum is formed
  typedef enum int { CHK_GOOD, CHK_NEAR, CHK_RAND, CHK_MIN, CHK_MAX } chk_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [WIN_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // seq, ack, check, payload words 0..4 from bit 0 up
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // seq, ack check, payload words 0..4, zero pad
  logic [0:0]             out_tuser;   // kind
  logic                   out_tlast;
  int                     fail_count;
  int                     pending;

  // sender-side view of the receive window: base_seq follows next expected,
  // since each block is sent until every sequence number in it got through
  logic [SEQ_W-1:0] base_seq;
  int               eff_win;
  int               gap_max;
  int               burst_left;
  int               sent_cnt;
  logic             hold_req;
  bit               hold_done;

  selective_repeat_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  srr_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int rand_len();
    return ($urandom_range(0, 3) == 0) ? PAYLOAD_BYTES : int'($urandom_range(0, PAYLOAD_BYTES));
  endfunction

  function automatic fill_t rand_fill();
    case ($urandom_range(0, 9))
      0: return FILL_MIN;
      1: return FILL_MAX;
      2: return FILL_NEG1;
      default: return FILL_RAND;
    endcase
  endfunction

  // Builds one packet and offers it until the transfer. Called at a falling edge,
  // returns at the falling edge after the transfer. The checksum is summed up
  // while the bytes are picked; bytes after the zero terminator are junk.
  task automatic send_pkt(input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] ack,
                          input int len, input fill_t fill, input chk_t chk);
    logic [PAY_W-1:0] pay;
    logic [7:0]       b;
    logic [CHK_W-1:0] cv;
    int               sum, gap, d;
    sum = int'(seq) + int'(ack);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (i < len) begin
        case (fill)
          FILL_MIN:  b = 8'h80;
          FILL_MAX:  b = 8'h7F;
          FILL_NEG1: b = 8'hFF;
          default:   b = 8'($urandom_range(1, 255));
        endcase
        sum += int'($signed(b));
      end else if (i == len) begin
        b = 8'h00;
      end else begin
        b = 8'($urandom);
      end
      pay[8*i +: 8] = b;
    end
    d = $urandom_range(1, 300);
    case (chk)
      CHK_GOOD: cv = sum;
      CHK_NEAR: cv = ($urandom_range(0, 1) == 0) ? sum + d : sum - d;
      CHK_MIN:  cv = 32'h8000_0000;
      CHK_MAX:  cv = 32'h7FFF_FFFF;
      default:  cv = $urandom;
    endcase
    // bursts of back-to-back packets with random gaps between them
    if (burst_left <= 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tdata  <= {pay, cv, ack, seq};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_good(input logic [SEQ_W-1:0] seq);
    send_pkt(seq, 16'($urandom), rand_len(), rand_fill(), CHK_GOOD);
  endtask

  // sender pause: every expected result is in, then the pipeline runs empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input int v);
    wait_drained();
    cfg_wr_data <= WIN_W'(v);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    eff_win = (v == 0) ? 1 : (v > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : v;
  endtask

  // Up to one window's worth (b) of sequence numbers, base_seq upward, in shuffled (or
  // reversed) order. Mixed in: corrupt copies, re-sends from the previous window,
  // duplicates, and noise far outside both windows. Each number in the block gets
  // through at least once, so next expected ends at base_seq + b.
  task automatic run_block(input int b, input bit rev);
    int               order [WINDOW_MAX_DEF];
    int               j, t;
    logic [SEQ_W-1:0] s;
    for (int i = 0; i < b; i++) order[i] = rev ? b - 1 - i : i;
    if (!rev) begin
      for (int i = b - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int k = 0; k < b; k++) begin
      s = base_seq + SEQ_W'(order[k]);
      if ($urandom_range(0, 99) < 15)
        send_pkt(s, 16'($urandom), rand_len(), rand_fill(),
                 ($urandom_range(0, 3) == 0) ? CHK_RAND : CHK_NEAR);
      if ($urandom_range(0, 99) < 10)
        send_good(base_seq - SEQ_W'(1 + $urandom_range(0, eff_win - 1)));
      if ($urandom_range(0, 99) < 6)
        send_good(base_seq + SEQ_W'(32 + $urandom_range(0, 65472)));
      if ($urandom_range(0, 99) < 4)
        send_pkt(16'($urandom), 16'($urandom), rand_len(), FILL_RAND, CHK_RAND);
      if (k > 0 && $urandom_range(0, 99) < 10)
        send_good(base_seq + SEQ_W'(order[$urandom_range(0, k - 1)]));
      send_good(s);
    end
    base_seq += SEQ_W'(b);
  endtask

  // Receiver: changes its ready pattern every so often (always ready down to
  // mostly stalled) and once holds off for a long stretch on request.
  initial begin : rx_ready
    int mode_left, pct;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    mode_left  = 0;
    pct        = 100;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 160);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 80;
          2: pct = 50;
          default: pct = 20;
        endcase
      end
      mode_left--;
      out_tready <= ($urandom_range(1, 100) <= pct);
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("FAIL selective_repeat_receiver");
    $finish;
  end

  initial begin : stimulus
    int phase, win, nblk;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    hold_req    = 1'b0;
    base_seq    = '0;
    eff_win     = int'(WIN_RESET);
    gap_max     = 3;
    burst_left  = 0;
    sent_cnt    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, window 8 from reset, next expected 0.
    send_pkt(16'd0, 16'hFFFF, 20, FILL_MAX, CHK_NEAR);     // corrupt: no result
    send_pkt(16'd2, 16'h0000, 20, FILL_MIN, CHK_GOOD);     // ahead of order: ack, stored
    send_pkt(16'd1, 16'h1234, 0, FILL_RAND, CHK_GOOD);     // empty payload
    send_pkt(16'd2, 16'hFFFF, 20, FILL_RAND, CHK_GOOD);    // duplicate: stored payload kept
    send_good(16'd8);                                      // one past the window: ignored
    send_pkt(16'd7, 16'h8000, 20, FILL_NEG1, CHK_GOOD);    // last slot of the window
    send_pkt(16'd0, 16'h0001, 5, FILL_MAX, CHK_GOOD);      // fills the gap: 0..2 delivered
    send_good(16'd0);                                      // previous window: re-ack
    send_good(16'hFFFF);                                   // previous window across the wrap
    send_good(16'hFFFA);                                   // below previous window: ignored
    send_pkt(16'hC3A5, 16'($urandom), 20, FILL_RAND, CHK_MIN);
    send_pkt(16'h5A3C, 16'($urandom), 20, FILL_RAND, CHK_MAX);
    send_good(16'd3);
    send_good(16'd4);
    send_good(16'd5);
    send_good(16'd6);                                      // delivers 6 and the stored 7
    send_good(16'd13);                                     // stored ahead of next expected 8
    // window register 0 acts as 1; slot 13 stays filled across the change
    set_window(0);
    send_good(16'd9);                                      // outside a one-wide window
    send_good(16'd8);                                      // ack and deliver 8 only
    send_good(16'd7);                                      // two below: ignored at width 1
    base_seq = 16'd9;

    // Random part: a window setting per phase, then several blocks.
    // Phase 0 saturates the window and sends a full block in reverse, so the
    // last packet releases a run of 16 deliveries. Phase 1 carries the long
    // receiver hold-off while the sender keeps pushing without gaps.
    phase = 0;
    while (sent_cnt < ITEM_TARGET) begin
      case (phase)
        0: win = 31;
        1: win = 16;
        2: win = 1;
        3: win = 0;
        4: win = 5;
        5: win = 16;
        default: win = $urandom_range(0, 31);
      endcase
      set_window(win);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (phase == 1) begin
        hold_req <= 1'b1;
        gap_max = 0;
      end
      nblk = (phase == 0) ? 1 : $urandom_range(2, 5);
      for (int n = 0; n < nblk; n++) begin
        if (phase == 0) run_block(eff_win, 1'b1);
        else run_block(($urandom_range(0, 2) == 0) ? $urandom_range(1, eff_win) : eff_win,
                       1'b0);
      end
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS selective_repeat_receiver");
    end else begin
      $display("FAIL selective_repeat_receiver");
    end
    $finish;
  end

endmodule
